// ===== rtl/core/mma_pkg.sv =====
package mma_pkg;

    // Seven signed motion and rate channels, then one unsigned pressure channel
    localparam int NUM_SIG    = 7;
    localparam int NUM_LANES  = NUM_SIG + 1;

    // Depth of the result queue; also bounds the words in flight
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    // Depth of the valid pipeline from accept to queue push
    localparam int PIPE_DEPTH = 5;

    // Per-word control shared by all lanes
    typedef struct packed {
        logic wr;      // word accepted this cycle: write slot, fetch leaving sample
        logic upd;     // leaving sample is now registered: update running sum
        logic old_ok;  // slot held a real sample, otherwise it reads as zero
    } t_lane_ctl;

endpackage

// ===== rtl/core/mma_lane.sv =====
module mma_lane
    import mma_pkg::*;
#(
    parameter int WINDOW      = 200,
    parameter int W_IN        = 16,
    parameter bit SIGNED_LANE = 1'b1
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  t_lane_ctl                   i_ctl,
    input  logic [$clog2(WINDOW)-1:0]   i_slot,
    input  logic [W_IN-1:0]             i_sample,
    output logic [W_IN-1:0]             o_avg
);

    localparam int LOG_W  = $clog2(WINDOW);
    localparam int SUM_W  = W_IN + LOG_W;
    localparam int SHIFT  = SUM_W + LOG_W;
    localparam int PROD_W = 2 * SUM_W + 1;
    // Reciprocal of WINDOW, exact for every magnitude below 2**SUM_W
    localparam logic [63:0] MUL_K =
        ((64'd1 << SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);

    logic [W_IN-1:0]   r_mem [WINDOW];
    logic [W_IN-1:0]   r_rd;
    logic [W_IN-1:0]   r_new;
    logic [SUM_W-1:0]  r_sum;
    logic [SUM_W-1:0]  n_sum;
    logic [W_IN-1:0]   old_smp;
    logic [SUM_W-1:0]  new_ext;
    logic [SUM_W-1:0]  old_ext;
    logic [SUM_W-1:0]  r_mag;
    logic              r_neg;
    logic              r_neg_p;
    logic [PROD_W-1:0] r_prod;
    logic [W_IN-1:0]   quot;
    logic [W_IN-1:0]   r_avg;

    // Window ring: fetch the leaving sample, then overwrite it with the new one
    always_ff @(posedge i_clk) begin
        r_rd  <= r_mem[i_slot];
        r_new <= i_sample;
        if (i_ctl.wr) begin
            r_mem[i_slot] <= i_sample;
        end
    end

    // Extend both samples to sum width
    always_comb begin
        old_smp = i_ctl.old_ok ? r_rd : '0;
        if (SIGNED_LANE) begin
            new_ext = {{LOG_W{r_new[W_IN-1]}}, r_new};
            old_ext = {{LOG_W{old_smp[W_IN-1]}}, old_smp};
        end else begin
            new_ext = {{LOG_W{1'b0}}, r_new};
            old_ext = {{LOG_W{1'b0}}, old_smp};
        end
        n_sum = r_sum + new_ext - old_ext;
    end

    // Running sum: add the new sample, drop the leaving one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
        end else if (i_ctl.upd) begin
            r_sum <= n_sum;
        end
    end

    // Split sum into sign and magnitude so the quotient truncates toward zero
    always_ff @(posedge i_clk) begin
        if (SIGNED_LANE && r_sum[SUM_W-1]) begin
            r_mag <= ~r_sum + 1'b1;
            r_neg <= 1'b1;
        end else begin
            r_mag <= r_sum;
            r_neg <= 1'b0;
        end
    end

    // Multiply by the reciprocal
    always_ff @(posedge i_clk) begin
        r_prod  <= {{(SUM_W + 1){1'b0}}, r_mag} * {{SUM_W{1'b0}}, MUL_K[SUM_W:0]};
        r_neg_p <= r_neg;
    end

    assign quot = r_prod[SHIFT +: W_IN];

    // Restore the sign
    always_ff @(posedge i_clk) begin
        r_avg <= r_neg_p ? (~quot + 1'b1) : quot;
    end

    assign o_avg = r_avg;

endmodule

// ===== rtl/core/mma_merge.sv =====
module mma_merge
    import mma_pkg::*;
#(
    parameter int SAMPLE_WIDTH   = 16,
    parameter int PRESSURE_WIDTH = 24,
    parameter int DATA_W         = 136
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_push,
    input  logic [SAMPLE_WIDTH-1:0]   i_avg_sig [NUM_SIG],
    input  logic [PRESSURE_WIDTH-1:0] i_avg_prs,
    input  logic                      i_pop,
    output logic                      o_tvalid,
    output logic [DATA_W-1:0]         o_tdata
);

    localparam int PAY_W = NUM_SIG * SAMPLE_WIDTH + PRESSURE_WIDTH;

    logic [DATA_W-1:0]  word;
    logic [DATA_W-1:0]  r_q [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wp;
    logic [FIFO_AW-1:0] r_rp;
    logic [FIFO_CW-1:0] r_cnt;

    // Pack lane results into one word, first channel lowest, zero padding on top
    always_comb begin
        word = '0;
        for (int c = 0; c < NUM_SIG; c++) begin
            word[c * SAMPLE_WIDTH +: SAMPLE_WIDTH] = i_avg_sig[c];
        end
        word[NUM_SIG * SAMPLE_WIDTH +: PRESSURE_WIDTH] = i_avg_prs;
    end

    // Result queue storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wp] <= word;
        end
    end

    // Queue pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + FIFO_CW'(i_push) - FIFO_CW'(i_pop);
        end
    end

    assign o_tvalid = (r_cnt != '0);
    assign o_tdata  = r_q[r_rp];

    // Padding bits above the payload are constant zero
    if (DATA_W < PAY_W) begin : g_width_check
        $error("tdata narrower than payload");
    end

endmodule

// ===== rtl/core/multichannel_moving_average.sv =====
// Boxcar moving average over the last WINDOW sensor frames, eight channels in parallel.
// Each input word carries seven signed samples (roll, pitch, accel x/y, rates p/q/r) and
// one unsigned pressure sample; each output word carries the window average of every
// channel, the exact sum divided by WINDOW and truncated toward zero. After reset the
// window counts as all zeros, so the first WINDOW-1 results average those zeros in; a
// bit per ring slot marks it empty at once, with no clearing pass. One word is taken
// every cycle while input ready is high: per word, each lane does one window memory read
// and write and one running-sum update. A result is registered as sum, magnitude, product
// and average, then queued; input ready drops only while 8 words are queued or in flight.
module multichannel_moving_average
    import mma_pkg::*;
#(
    parameter int WINDOW         = 200,
    parameter int SAMPLE_WIDTH   = 16,
    parameter int PRESSURE_WIDTH = 24,
    localparam int DATA_W = ((NUM_SIG * SAMPLE_WIDTH + PRESSURE_WIDTH + 7) / 8) * 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    // roll_angle, pitch_angle, accel_x, accel_y, rate_p, rate_q, rate_r, baro_pressure
    input  logic [DATA_W-1:0] s_axis_tdata,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    // avg_roll, avg_pitch, avg_accel_x, avg_accel_y, avg_rate_p, avg_rate_q, avg_rate_r,
    // avg_pressure
    output logic [DATA_W-1:0] m_axis_tdata
);

    localparam int SLOT_W = $clog2(WINDOW);

    logic                      accept;
    logic                      pop;
    logic [SLOT_W-1:0]         r_slot;
    logic [WINDOW-1:0]         r_slot_ok;
    logic                      r_old_ok;
    logic [PIPE_DEPTH-1:0]     r_pipe_v;
    logic [FIFO_CW-1:0]        r_credit;
    t_lane_ctl                 lane_ctl;
    logic [SAMPLE_WIDTH-1:0]   avg_sig [NUM_SIG];
    logic [PRESSURE_WIDTH-1:0] avg_prs;

    assign accept        = s_axis_tvalid & s_axis_tready;
    assign pop           = m_axis_tvalid & m_axis_tready;
    assign s_axis_tready = (r_credit < FIFO_CW'(FIFO_DEPTH));

    // Ring pointer, slot occupancy bits and words in flight
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot    <= '0;
            r_slot_ok <= '0;
            r_old_ok  <= 1'b0;
            r_pipe_v  <= '0;
            r_credit  <= '0;
        end else begin
            if (accept) begin
                r_old_ok          <= r_slot_ok[r_slot];
                r_slot_ok[r_slot] <= 1'b1;
                r_slot            <= (r_slot == SLOT_W'(WINDOW - 1)) ? '0 : r_slot + 1'b1;
            end
            r_pipe_v <= {r_pipe_v[PIPE_DEPTH-2:0], accept};
            r_credit <= r_credit + FIFO_CW'(accept) - FIFO_CW'(pop);
        end
    end

    always_comb begin
        lane_ctl.wr     = accept;
        lane_ctl.upd    = r_pipe_v[0];
        lane_ctl.old_ok = r_old_ok;
    end

    // Signed channel lanes
    for (genvar c = 0; c < NUM_SIG; c++) begin : g_sig
        mma_lane #(
            .WINDOW      (WINDOW),
            .W_IN        (SAMPLE_WIDTH),
            .SIGNED_LANE (1'b1)
        ) u_lane (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_ctl    (lane_ctl),
            .i_slot   (r_slot),
            .i_sample (s_axis_tdata[c * SAMPLE_WIDTH +: SAMPLE_WIDTH]),
            .o_avg    (avg_sig[c])
        );
    end

    // Pressure lane
    mma_lane #(
        .WINDOW      (WINDOW),
        .W_IN        (PRESSURE_WIDTH),
        .SIGNED_LANE (1'b0)
    ) u_prs_lane (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (lane_ctl),
        .i_slot   (r_slot),
        .i_sample (s_axis_tdata[NUM_SIG * SAMPLE_WIDTH +: PRESSURE_WIDTH]),
        .o_avg    (avg_prs)
    );

    // Pack and queue results
    mma_merge #(
        .SAMPLE_WIDTH   (SAMPLE_WIDTH),
        .PRESSURE_WIDTH (PRESSURE_WIDTH),
        .DATA_W         (DATA_W)
    ) u_merge (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (r_pipe_v[PIPE_DEPTH-1]),
        .i_avg_sig (avg_sig),
        .i_avg_prs (avg_prs),
        .i_pop     (pop),
        .o_tvalid  (m_axis_tvalid),
        .o_tdata   (m_axis_tdata)
    );

endmodule

// ===== tb/tb_multichannel_moving_average.sv =====
module tb_multichannel_moving_average
    import mma_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WIN          = 200;
    localparam int SW           = 16;
    localparam int PW           = 24;
    localparam int DATA_W       = ((NUM_SIG * SW + PW + 7) / 8) * 8;
    localparam int RANDOM_ITEMS = 1800;
    localparam int CALM_ITEMS   = 200;
    localparam int LONG_HOLD    = 120;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int PRINT_CAP    = 40;

    // One sensor frame or one average word; channel 0 sits in the lowest bits
    typedef struct packed {
        logic [PW-1:0]              pres;
        logic [NUM_SIG-1:0][SW-1:0] ch;
    } t_frame;

    typedef enum int {
        FILL_RANDOM,
        FILL_MAX,
        FILL_MIN,
        FILL_SMALL,
        FILL_CORNERS
    } t_pattern;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [DATA_W-1:0] s_axis_tdata;
    logic              m_axis_tvalid;
    logic              m_axis_tready;
    logic [DATA_W-1:0] m_axis_tdata;

    // Window copy kept alongside the block
    logic signed [SW-1:0] win_sig [WIN][NUM_SIG];
    logic [PW-1:0]        win_pres [WIN];
    longint               sig_sum [NUM_SIG];
    longint               pres_sum;
    int                   ring_pos;

    t_frame expected_avgs [$];
    t_frame dir_frames [$];
    t_frame dir_expect [$];
    bit     dir_typed [$];

    int mismatch_count = 0;
    int cycle_count    = 0;
    bit calm           = 1'b0;
    bit hold_req       = 1'b0;

    multichannel_moving_average #(
        .WINDOW         (WIN),
        .SAMPLE_WIDTH   (SW),
        .PRESSURE_WIDTH (PW)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        // roll_angle, pitch_angle, accel_x, accel_y, rate_p, rate_q, rate_r, baro_pressure
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        // avg_roll, avg_pitch, avg_accel_x, avg_accel_y, avg_rate_p, avg_rate_q,
        // avg_rate_r, avg_pressure
        .m_axis_tdata  (m_axis_tdata)
    );

    // Clock, 12 ns period
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic report_mismatch(string msg);
        if (mismatch_count < PRINT_CAP)
            $display("MISMATCH at %0t ns: %s", $time, msg);
        mismatch_count++;
    endtask

    // Replace the oldest slot, update the running sums and divide
    function automatic t_frame average_window(t_frame f);
        t_frame r;
        longint avg;
        for (int c = 0; c < NUM_SIG; c++) begin
            sig_sum[c] += longint'($signed(f.ch[c])) - longint'(win_sig[ring_pos][c]);
            win_sig[ring_pos][c] = f.ch[c];
            avg = sig_sum[c] / WIN;
            r.ch[c] = avg[SW-1:0];
        end
        pres_sum += longint'(f.pres) - longint'(win_pres[ring_pos]);
        win_pres[ring_pos] = f.pres;
        avg = pres_sum / WIN;
        r.pres = avg[PW-1:0];
        ring_pos = (ring_pos + 1) % WIN;
        return r;
    endfunction

    function automatic t_frame uniform(logic [SW-1:0] s, logic [PW-1:0] p);
        t_frame f;
        for (int c = 0; c < NUM_SIG; c++)
            f.ch[c] = s;
        f.pres = p;
        return f;
    endfunction

    function automatic t_frame mixed(logic [SW-1:0] s0, logic [SW-1:0] s1, logic [SW-1:0] s2,
                                     logic [SW-1:0] s3, logic [SW-1:0] s4, logic [SW-1:0] s5,
                                     logic [SW-1:0] s6, logic [PW-1:0] p);
        t_frame f;
        f.ch = {s6, s5, s4, s3, s2, s1, s0};
        f.pres = p;
        return f;
    endfunction

    function automatic t_frame rand_frame(t_pattern mode);
        t_frame f;
        for (int c = 0; c < NUM_SIG; c++) begin
            case (mode)
                FILL_MAX:     f.ch[c] = {1'b0, {(SW-1){1'b1}}};
                FILL_MIN:     f.ch[c] = {1'b1, {(SW-1){1'b0}}};
                FILL_SMALL:   f.ch[c] = SW'($urandom_range(0, 64) - 32);
                FILL_CORNERS: f.ch[c] = $urandom_range(0, 1) ? {1'b0, {(SW-1){1'b1}}}
                                                              : {1'b1, {(SW-1){1'b0}}};
                default:      f.ch[c] = SW'($urandom);
            endcase
        end
        case (mode)
            FILL_MAX:     f.pres = {PW{1'b1}};
            FILL_MIN:     f.pres = '0;
            FILL_SMALL:   f.pres = PW'($urandom_range(0, 255));
            FILL_CORNERS: f.pres = $urandom_range(0, 1) ? {PW{1'b1}} : '0;
            default:      f.pres = PW'($urandom);
        endcase
        return f;
    endfunction

    task automatic add_row(t_frame f, bit typed, t_frame e);
        dir_frames.push_back(f);
        dir_typed.push_back(typed);
        dir_expect.push_back(e);
    endtask

    // Offer one word and hold it until taken; caller stands at a rising edge
    task automatic send_frame(t_frame f, bit typed, t_frame typed_exp);
        t_frame predicted;
        bit     rdy;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= f;
        do begin
            @(negedge i_clk);
            rdy = s_axis_tready;
            @(posedge i_clk);
        end while (!rdy);
        predicted = average_window(f);
        expected_avgs.push_back(typed ? typed_exp : predicted);
    endtask

    // Random gap on the input side
    task automatic sender_gap();
        if (!calm && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
    endtask

    // Stop offering until every expected word has come back
    task automatic drain();
        if (expected_avgs.size() != 0) begin
            s_axis_tvalid <= 1'b0;
            while (expected_avgs.size() != 0)
                @(posedge i_clk);
        end
    endtask

    // Output side: random stalls, one long hold-off, none near the end
    initial begin : sink
        bit held;
        held = 1'b0;
        m_axis_tready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (hold_req && !held) begin
                held = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else if (!calm && $urandom_range(0, 3) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
        end
    end

    // Compare each word taken from the output with the oldest expectation
    always @(negedge i_clk) begin
        t_frame got;
        t_frame exp_avg;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata;
            if (expected_avgs.size() == 0) begin
                report_mismatch($sformatf("unexpected word %h", m_axis_tdata));
            end else begin
                exp_avg = expected_avgs.pop_front();
                for (int c = 0; c < NUM_SIG; c++) begin
                    if (got.ch[c] !== exp_avg.ch[c])
                        report_mismatch($sformatf("channel %0d got %0d expected %0d", c,
                                                  $signed(got.ch[c]), $signed(exp_avg.ch[c])));
                end
                if (got.pres !== exp_avg.pres)
                    report_mismatch($sformatf("pressure got %0d expected %0d",
                                              got.pres, exp_avg.pres));
            end
        end
    end

    // Stimulus
    initial begin : source
        t_frame   none;
        t_pattern mode;
        int       sent;
        int       run;
        int       pick;

        none          = '0;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        for (int i = 0; i < WIN; i++) begin
            win_pres[i] = '0;
            for (int c = 0; c < NUM_SIG; c++)
                win_sig[i][c] = '0;
        end
        for (int c = 0; c < NUM_SIG; c++)
            sig_sum[c] = 0;
        pres_sum = 0;
        ring_pos = 0;

        // Extremes straight after reset: the zeros of the empty window count,
        // and negative averages truncate toward zero
        add_row(uniform(16'h0000, 24'h000000), 1'b1, uniform(16'h0000, 24'h000000));
        add_row(uniform(16'h7FFF, 24'hFFFFFF), 1'b1, uniform(16'd163, 24'd83886));
        add_row(uniform(16'h8000, 24'h000000), 1'b1, uniform(16'h0000, 24'd83886));
        add_row(uniform(16'h8000, 24'h000000), 1'b1, uniform(16'(-163), 24'd83886));
        add_row(uniform(16'h8000, 24'h000000), 1'b1, uniform(16'(-327), 24'd83886));
        // Bit patterns and mixed signs, checked against the running window
        add_row(uniform(16'h5555, 24'h555555), 1'b0, none);
        add_row(uniform(16'hAAAA, 24'hAAAAAA), 1'b0, none);
        add_row(uniform(16'hFFFF, 24'h000001), 1'b0, none);
        add_row(uniform(16'h0001, 24'h800000), 1'b0, none);
        add_row(mixed(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000,
                      16'h7FFF, 24'h7FFFFF), 1'b0, none);
        add_row(mixed(16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF,
                      16'h8000, 24'hFFFFFF), 1'b0, none);
        add_row(mixed(16'd1, 16'hFFFF, 16'd2, 16'hFFFE, 16'd3, 16'hFFFD, 16'd200,
                      24'd200), 1'b0, none);
        add_row(mixed(16'h0001, 16'h0002, 16'h0004, 16'h0008, 16'h0010, 16'h0020,
                      16'h0040, 24'h000080), 1'b0, none);
        add_row(mixed(16'h0100, 16'h0200, 16'h0400, 16'h0800, 16'h1000, 16'h2000,
                      16'h4000, 24'h010000), 1'b0, none);
        add_row(mixed(16'hFF00, 16'h00FF, 16'hF0F0, 16'h0F0F, 16'hCCCC, 16'h3333,
                      16'h8001, 24'h0F0F0F), 1'b0, none);
        add_row(uniform(16'h7FFF, 24'hFFFFFF), 1'b0, none);
        add_row(uniform(16'h7FFF, 24'hFFFFFF), 1'b0, none);
        add_row(uniform(16'h8000, 24'h000000), 1'b0, none);
        add_row(uniform(16'h0000, 24'h000000), 1'b0, none);

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // Walk the directed table
        for (int r = 0; r < dir_frames.size(); r++) begin
            send_frame(dir_frames[r], dir_typed[r], dir_expect[r]);
            sender_gap();
        end
        drain();

        // Random runs: mostly random content, with long constant runs that
        // fill the window with extremes and wrap the ring
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 9);
            if (pick < 5)
                mode = FILL_RANDOM;
            else if (pick == 5)
                mode = FILL_MAX;
            else if (pick == 6)
                mode = FILL_MIN;
            else if (pick == 7)
                mode = FILL_SMALL;
            else
                mode = FILL_CORNERS;
            run = (mode == FILL_MAX || mode == FILL_MIN) ? $urandom_range(WIN, WIN + 40)
                                                         : $urandom_range(10, 150);
            for (int k = 0; k < run && sent < RANDOM_ITEMS; k++) begin
                calm = (sent >= RANDOM_ITEMS - CALM_ITEMS);
                if (sent == 500)
                    hold_req = 1'b1;
                if (sent == 1000)
                    drain();
                send_frame(rand_frame(mode), 1'b0, none);
                sender_gap();
                sent++;
            end
        end
        s_axis_tvalid <= 1'b0;

        // Wait for the last words, then allow for anything still in flight
        while (expected_avgs.size() != 0)
            @(posedge i_clk);
        repeat (4 * PIPE_DEPTH + FIFO_DEPTH) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
